// ===== hw/rtl/sxt_pkg.sv =====
// sxt_pkg: shared types and defaults for the s-expression tokenizer.
// Holds the lexer mode and token kind enums and the token and bundle structs.
// Depends on nothing; every sxt_* module and the top level use it.
`timescale 1ns / 1ps

package sxt_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned TEXT_BUFFER_SIZE_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF      = 4;

  // Largest value the integer accumulator may hold
  localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_INT     = 3'd2,
    MODE_STR     = 3'd3,
    MODE_ESC     = 3'd4,
    MODE_IDENT   = 3'd5
  } mode_t;

  // Token kinds as seen on the output port
  typedef enum logic [3:0] {
    KIND_LPAREN  = 4'd0,
    KIND_RPAREN  = 4'd1,
    KIND_QUOTE   = 4'd2,
    KIND_DOT     = 4'd3,
    KIND_INT     = 4'd4,
    KIND_CHAR    = 4'd5,
    KIND_STRDONE = 4'd6,
    KIND_IDDONE  = 4'd7,
    KIND_EOF     = 4'd8,
    KIND_ERROR   = 4'd9
  } kind_t;

  // One output token
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [30:0] val;
  } tok_t;

  // All tokens caused by one input word: one, or two when two is set
  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } bundle_t;

endpackage

// ===== hw/rtl/sxt_front.sv =====
// sxt_front: lexer front end; accepts one source word a cycle while accept is
// set, keeps the lexer mode, integer accumulator and text length, and bundles
// the tokens it causes. Depends on sxt_pkg.
`timescale 1ns / 1ps

module sxt_front #(
  parameter int unsigned TEXT_BUFFER_SIZE = sxt_pkg::TEXT_BUFFER_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_in,
  input  logic             end_of_input,
  output logic             push,
  output sxt_pkg::bundle_t push_data
);

  localparam int unsigned LenW = $clog2(TEXT_BUFFER_SIZE);
  localparam logic [LenW:0] LenLimit = (LenW + 1)'(TEXT_BUFFER_SIZE - 1);

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChBslash = 8'h5C;

  function automatic sxt_pkg::tok_t mk_tok(sxt_pkg::kind_t kind, logic [7:0] ch,
                                           logic [30:0] val);
    sxt_pkg::tok_t t;
    t.kind = kind;
    t.ch   = ch;
    t.val  = val;
    return t;
  endfunction

  sxt_pkg::mode_t mode, mode_next;
  logic [30:0]    acc, acc_next;
  logic [LenW-1:0] len, len_next;

  logic is_space, is_digit, is_dq, is_ident_ch, fits;
  logic [34:0] acc_ext, acc_mul;
  logic [30:0] acc_step;

  sxt_pkg::mode_t idle_mode;
  logic           idle_emit;
  sxt_pkg::tok_t  idle_tok;
  logic [30:0]    idle_acc;
  logic [LenW-1:0] idle_len;

  sxt_pkg::tok_t   tb_tok;
  logic [LenW-1:0] tb_len;

  logic          emit0, emit1;
  sxt_pkg::tok_t tok0, tok1;

  // Classify the incoming byte
  assign is_space    = (byte_in == ChSpace) || (byte_in == ChTab) ||
                       (byte_in == ChLf) || (byte_in == ChCr);
  assign is_digit    = (byte_in >= ChZero) && (byte_in <= ChNine);
  assign is_dq       = (byte_in == ChDquote);
  assign is_ident_ch = !is_space && !is_dq && (byte_in != ChLparen) &&
                       (byte_in != ChRparen);
  assign fits        = ({1'b0, len} < LenLimit);

  // Accumulate one decimal digit with saturation: acc*10 + digit
  assign acc_ext  = {4'b0, acc};
  assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + {31'b0, byte_in[3:0]};
  assign acc_step = (|acc_mul[34:31]) ? sxt_pkg::INT_MAX : acc_mul[30:0];

  // Append one text byte, or flag an overlong text
  assign tb_tok = fits ? mk_tok(sxt_pkg::KIND_CHAR, byte_in, 31'b0)
                       : mk_tok(sxt_pkg::KIND_ERROR, 8'b0, 31'b0);
  assign tb_len = fits ? len + LenW'(1) : '0;

  // Lex the byte as if between tokens
  always_comb begin
    idle_mode = sxt_pkg::MODE_IDLE;
    idle_emit = 1'b0;
    idle_tok  = mk_tok(sxt_pkg::KIND_EOF, 8'b0, 31'b0);
    idle_acc  = '0;
    idle_len  = '0;
    if (is_space) begin
      idle_mode = sxt_pkg::MODE_IDLE;
    end else if (byte_in == ChSemi) begin
      idle_mode = sxt_pkg::MODE_COMMENT;
    end else if (byte_in == ChLparen) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(sxt_pkg::KIND_LPAREN, 8'b0, 31'b0);
    end else if (byte_in == ChRparen) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(sxt_pkg::KIND_RPAREN, 8'b0, 31'b0);
    end else if (byte_in == ChQuote) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(sxt_pkg::KIND_QUOTE, 8'b0, 31'b0);
    end else if (byte_in == ChDot) begin
      idle_emit = 1'b1;
      idle_tok  = mk_tok(sxt_pkg::KIND_DOT, 8'b0, 31'b0);
    end else if (is_dq) begin
      idle_mode = sxt_pkg::MODE_STR;
    end else if (is_digit) begin
      idle_mode = sxt_pkg::MODE_INT;
      idle_acc  = {27'b0, byte_in[3:0]};
    end else begin
      // identifier start always fits: the buffer holds at least one byte
      idle_mode = sxt_pkg::MODE_IDENT;
      idle_emit = 1'b1;
      idle_tok  = mk_tok(sxt_pkg::KIND_CHAR, byte_in, 31'b0);
      idle_len  = LenW'(1);
    end
  end

  // Next lexer mode
  always_comb begin
    mode_next = mode;
    if (end_of_input) begin
      mode_next = sxt_pkg::MODE_IDLE;
    end else begin
      case (mode)
        sxt_pkg::MODE_COMMENT: begin
          if (byte_in == ChLf) mode_next = sxt_pkg::MODE_IDLE;
        end
        sxt_pkg::MODE_INT: begin
          if (!is_digit) mode_next = idle_mode;
        end
        sxt_pkg::MODE_STR: begin
          if (is_dq || !fits) mode_next = sxt_pkg::MODE_IDLE;
          else if (byte_in == ChBslash) mode_next = sxt_pkg::MODE_ESC;
          else mode_next = sxt_pkg::MODE_STR;
        end
        sxt_pkg::MODE_ESC: begin
          mode_next = fits ? sxt_pkg::MODE_STR : sxt_pkg::MODE_IDLE;
        end
        sxt_pkg::MODE_IDENT: begin
          if (is_ident_ch) mode_next = fits ? sxt_pkg::MODE_IDENT : sxt_pkg::MODE_IDLE;
          else mode_next = idle_mode;
        end
        default: begin
          mode_next = idle_mode;
        end
      endcase
    end
  end

  // Tokens and data state for this byte
  always_comb begin
    emit0    = 1'b0;
    emit1    = 1'b0;
    tok0     = mk_tok(sxt_pkg::KIND_EOF, 8'b0, 31'b0);
    tok1     = mk_tok(sxt_pkg::KIND_EOF, 8'b0, 31'b0);
    acc_next = acc;
    len_next = len;
    if (end_of_input) begin
      acc_next = '0;
      len_next = '0;
      emit0    = 1'b1;
      case (mode)
        sxt_pkg::MODE_INT: begin
          tok0  = mk_tok(sxt_pkg::KIND_INT, 8'b0, acc);
          emit1 = 1'b1;
        end
        sxt_pkg::MODE_IDENT: begin
          tok0  = mk_tok(sxt_pkg::KIND_IDDONE, 8'b0, 31'b0);
          emit1 = 1'b1;
        end
        sxt_pkg::MODE_COMMENT, sxt_pkg::MODE_STR, sxt_pkg::MODE_ESC: begin
          tok0 = mk_tok(sxt_pkg::KIND_ERROR, 8'b0, 31'b0);
        end
        default: begin
          tok0 = mk_tok(sxt_pkg::KIND_EOF, 8'b0, 31'b0);
        end
      endcase
    end else begin
      case (mode)
        sxt_pkg::MODE_COMMENT: begin
          emit0 = 1'b0;
        end
        sxt_pkg::MODE_INT: begin
          if (is_digit) begin
            acc_next = acc_step;
          end else begin
            emit0    = 1'b1;
            tok0     = mk_tok(sxt_pkg::KIND_INT, 8'b0, acc);
            emit1    = idle_emit;
            tok1     = idle_tok;
            acc_next = idle_acc;
            len_next = idle_len;
          end
        end
        sxt_pkg::MODE_STR: begin
          emit0 = 1'b1;
          if (is_dq) begin
            tok0     = mk_tok(sxt_pkg::KIND_STRDONE, 8'b0, 31'b0);
            len_next = '0;
          end else begin
            tok0     = tb_tok;
            len_next = tb_len;
          end
        end
        sxt_pkg::MODE_ESC: begin
          emit0    = 1'b1;
          tok0     = tb_tok;
          len_next = tb_len;
        end
        sxt_pkg::MODE_IDENT: begin
          emit0 = 1'b1;
          if (is_ident_ch) begin
            tok0     = tb_tok;
            len_next = tb_len;
          end else begin
            tok0     = mk_tok(sxt_pkg::KIND_IDDONE, 8'b0, 31'b0);
            emit1    = idle_emit;
            tok1     = idle_tok;
            acc_next = idle_acc;
            len_next = idle_len;
          end
        end
        default: begin
          emit0    = idle_emit;
          tok0     = idle_tok;
          acc_next = idle_acc;
          len_next = idle_len;
        end
      endcase
    end
  end

  // Hand a bundle to the queue whenever the word causes any token
  assign push             = accept && emit0;
  assign push_data.two    = emit1;
  assign push_data.first  = tok0;
  assign push_data.second = tok1;

  // Advance the lexer state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sxt_pkg::MODE_IDLE;
      acc  <= '0;
      len  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      len  <= len_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == sxt_pkg::MODE_IDLE && acc == '0 && len == '0)
    else $error("end of input did not return the lexer to idle");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, len} <= LenLimit)
    else $error("text length ran past the buffer size");
`endif

endmodule

// ===== hw/rtl/sxt_queue.sv =====
// sxt_queue: short register queue of token bundles between front and back end.
// Depends on sxt_pkg.
`timescale 1ns / 1ps

module sxt_queue #(
  parameter int unsigned QUEUE_DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sxt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output sxt_pkg::bundle_t pop_data,
  output logic             empty
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  sxt_pkg::bundle_t store [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  // Hold bundles
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed when full or popped when empty");
`endif

endmodule

// ===== hw/rtl/sxt_back.sv =====
// sxt_back: back end; unpacks queued token bundles and, when not stalled,
// presents one token word a cycle on the output register. Depends on sxt_pkg.
`timescale 1ns / 1ps

module sxt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sxt_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output sxt_pkg::tok_t    out_tok,
  output logic             out_last
);

  logic          pend_valid;
  sxt_pkg::tok_t pend_tok;
  logic          load;

  // The output register is free when empty or being taken
  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !pend_valid && !q_empty;

  // Control: output valid and pending second token
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid  <= 1'b1;
        pend_valid <= q_data.two;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Payload: present the first token, park the second
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_tok  <= pend_tok;
        out_last <= 1'b1;
      end else if (!q_empty) begin
        out_tok  <= q_data.first;
        out_last <= !q_data.two;
        pend_tok <= q_data.second;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid && !out_last)
    else $error("second token parked without its first on the output");

  a_not_last_has_pend: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> pend_valid)
    else $error("non-final token shown with no second token parked");
`endif

endmodule

// ===== hw/rtl/sexpr_tokenizer.sv =====
// sexpr_tokenizer: top level of the byte-serial s-expression lexer.
// Ties the front end, token queue and back end together. Depends on sxt_pkg,
// sxt_front, sxt_queue and sxt_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | byte_in, end_of_input
//   out     | out_valid / out_stall| token_kind, text_char, int_value,
//           |                      | last_of_run
//
// One source word is accepted each cycle with in_valid high and in_stall low;
// it leaves the front end in that cycle and goes via the queue to the output
// register. A two-token word holds the back end for both, so the rate is
// one word a cycle while words give at most one token each and out_stall is
// low. in_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Synchronous reset returns the lexer to idle and empties queue and output.
`timescale 1ns / 1ps

module sexpr_tokenizer #(
  parameter int unsigned TEXT_BUFFER_SIZE = sxt_pkg::TEXT_BUFFER_SIZE_DEF,
  parameter int unsigned QUEUE_DEPTH      = sxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [7:0]  text_char,
  output logic [30:0] int_value,
  output logic        last_of_run
);

  logic             accept;
  logic             push, q_full, q_pop, q_empty;
  sxt_pkg::bundle_t push_data, q_data;
  sxt_pkg::tok_t    out_tok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  sxt_front #(
    .TEXT_BUFFER_SIZE(TEXT_BUFFER_SIZE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_in     (byte_in),
    .end_of_input(end_of_input),
    .push        (push),
    .push_data   (push_data)
  );

  sxt_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty)
  );

  sxt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tok  (out_tok),
    .out_last (last_of_run)
  );

  // Unpack the output token word
  assign token_kind = out_tok.kind;
  assign text_char  = out_tok.ch;
  assign int_value  = out_tok.val;

endmodule

// ===== test/sexpr_tokenizer_tb.sv =====
// sexpr_tokenizer_tb: self-checking testbench for the s-expression tokenizer.
// Predicts every token from the source words it sends and checks each output word
// in order, with random sender gaps and receiver stalls. Depends on sxt_pkg.
`timescale 1ns / 1ps

module sexpr_tokenizer_tb;

  localparam int unsigned TEXT_CAP       = sxt_pkg::TEXT_BUFFER_SIZE_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  // Source characters the lexer treats specially
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Classes of random source byte
  typedef enum int {
    PICK_SEP,
    PICK_IDENT_START,
    PICK_IDENT,
    PICK_STR,
    PICK_COMMENT
  } byte_class_e;

  typedef struct packed {
    sxt_pkg::kind_t kind;
    logic [7:0]     ch;
    logic [30:0]    val;
    logic           last;
  } token_rec_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in      = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [3:0]  token_kind;
  logic [7:0]  text_char;
  logic [30:0] int_value;
  logic        last_of_run;

  // Lexer state as the testbench sees it
  sxt_pkg::mode_t cur_mode   = sxt_pkg::MODE_IDLE;
  logic [30:0]    int_acc    = '0;
  int unsigned    text_count = 0;

  token_rec_t  word_tokens[$];
  token_rec_t  pending_tokens[$];

  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          error_count = 0;
  int          words_sent = 0;
  int          live_words = 0;
  int          tokens_checked = 0;
  int          kind_hits[16];

  sexpr_tokenizer #(
    .TEXT_BUFFER_SIZE(TEXT_CAP)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .text_char    (text_char),
    .int_value    (int_value),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit is_sep(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit ends_ident(logic [7:0] c);
    return is_sep(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE;
  endfunction

  function automatic void emit_token(sxt_pkg::kind_t k, logic [7:0] ch, logic [30:0] v);
    token_rec_t t;
    t.kind = k;
    t.ch   = ch;
    t.val  = v;
    t.last = 1'b0;
    word_tokens.push_back(t);
  endfunction

  // Keep one text character, or flag overflow and drop back to idle
  function automatic void keep_text_char(logic [7:0] c, sxt_pkg::mode_t next_mode);
    if (text_count + 1 < TEXT_CAP) begin
      emit_token(sxt_pkg::KIND_CHAR, c, '0);
      text_count++;
      cur_mode = next_mode;
    end else begin
      emit_token(sxt_pkg::KIND_ERROR, '0, '0);
      text_count = 0;
      cur_mode = sxt_pkg::MODE_IDLE;
    end
  endfunction

  // Lex a byte that arrives between tokens
  function automatic void lex_from_idle(logic [7:0] c);
    cur_mode = sxt_pkg::MODE_IDLE;
    if (is_sep(c)) return;
    case (c)
      CH_SEMI:   cur_mode = sxt_pkg::MODE_COMMENT;
      CH_LPAREN: emit_token(sxt_pkg::KIND_LPAREN, '0, '0);
      CH_RPAREN: emit_token(sxt_pkg::KIND_RPAREN, '0, '0);
      CH_QUOTE:  emit_token(sxt_pkg::KIND_QUOTE, '0, '0);
      CH_DOT:    emit_token(sxt_pkg::KIND_DOT, '0, '0);
      CH_DQUOTE: begin
        text_count = 0;
        cur_mode = sxt_pkg::MODE_STR;
      end
      default: begin
        if (is_digit(c)) begin
          int_acc = 31'(c - CH_ZERO);
          cur_mode = sxt_pkg::MODE_INT;
        end else begin
          text_count = 0;
          keep_text_char(c, sxt_pkg::MODE_IDENT);
        end
      end
    endcase
  endfunction

  // Advance the predicted lexer by one word and queue the tokens it gives.
  // Returns 0 when the word is merely skipped (separator or comment body).
  function automatic bit lex_word(logic [7:0] c, logic eoi);
    sxt_pkg::mode_t was;
    logic [34:0]    wide;
    was = cur_mode;
    word_tokens.delete();
    if (eoi) begin
      case (cur_mode)
        sxt_pkg::MODE_INT: begin
          emit_token(sxt_pkg::KIND_INT, '0, int_acc);
          emit_token(sxt_pkg::KIND_EOF, '0, '0);
        end
        sxt_pkg::MODE_IDENT: begin
          emit_token(sxt_pkg::KIND_IDDONE, '0, '0);
          emit_token(sxt_pkg::KIND_EOF, '0, '0);
        end
        sxt_pkg::MODE_COMMENT, sxt_pkg::MODE_STR, sxt_pkg::MODE_ESC:
          emit_token(sxt_pkg::KIND_ERROR, '0, '0);
        default: emit_token(sxt_pkg::KIND_EOF, '0, '0);
      endcase
      cur_mode = sxt_pkg::MODE_IDLE;
      int_acc = '0;
      text_count = 0;
    end else begin
      case (cur_mode)
        sxt_pkg::MODE_COMMENT: if (c == CH_LF) cur_mode = sxt_pkg::MODE_IDLE;
        sxt_pkg::MODE_INT: begin
          if (is_digit(c)) begin
            wide = {4'd0, int_acc} * 35'd10 + 35'(c - CH_ZERO);
            int_acc = (wide > 35'(sxt_pkg::INT_MAX)) ? sxt_pkg::INT_MAX : wide[30:0];
          end else begin
            emit_token(sxt_pkg::KIND_INT, '0, int_acc);
            int_acc = '0;
            lex_from_idle(c);
          end
        end
        sxt_pkg::MODE_STR: begin
          if (c == CH_DQUOTE) begin
            emit_token(sxt_pkg::KIND_STRDONE, '0, '0);
            text_count = 0;
            cur_mode = sxt_pkg::MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            keep_text_char(c, sxt_pkg::MODE_ESC);
          end else begin
            keep_text_char(c, sxt_pkg::MODE_STR);
          end
        end
        sxt_pkg::MODE_ESC: keep_text_char(c, sxt_pkg::MODE_STR);
        sxt_pkg::MODE_IDENT: begin
          if (!ends_ident(c)) begin
            keep_text_char(c, sxt_pkg::MODE_IDENT);
          end else begin
            emit_token(sxt_pkg::KIND_IDDONE, '0, '0);
            text_count = 0;
            lex_from_idle(c);
          end
        end
        default: lex_from_idle(c);
      endcase
    end
    // Mark the final token of this word
    foreach (word_tokens[i]) begin
      word_tokens[i].last = (i == word_tokens.size() - 1);
      pending_tokens.push_back(word_tokens[i]);
    end
    return !(word_tokens.size() == 0 && cur_mode == was &&
             (was == sxt_pkg::MODE_IDLE || was == sxt_pkg::MODE_COMMENT));
  endfunction

  // ------------------------------------------------------------------ stimulus

  function automatic logic [7:0] random_byte(byte_class_e cls);
    logic [7:0] b;
    bit         ok;
    ok = 1'b0;
    while (!ok) begin
      b = 8'($urandom_range(0, 255));
      case (cls)
        PICK_SEP:         ok = is_sep(b);
        PICK_IDENT_START: ok = !ends_ident(b) && !is_digit(b) &&
                               !(b inside {CH_SEMI, CH_QUOTE, CH_DOT});
        PICK_IDENT:       ok = !ends_ident(b);
        PICK_STR:         ok = b != CH_DQUOTE && b != CH_BSLASH;
        default:          ok = b != CH_LF;
      endcase
    end
    return b;
  endfunction

  // Send one word, with an occasional idle burst first; hold until accepted
  task automatic send_word(input logic [7:0] b, input logic eoi);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    byte_in      <= b;
    end_of_input <= eoi;
    if (lex_word(b, eoi)) live_words++;
    words_sent++;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Send one random construct: mostly well-formed tokens, some noise
  task automatic send_construct();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      case ($urandom_range(0, 3))
        0:       b = CH_LPAREN;
        1:       b = CH_RPAREN;
        2:       b = CH_QUOTE;
        default: b = CH_DOT;
      endcase
      send_word(b, 1'b0);
    end else if (pick < 18) begin
      n = $urandom_range(1, 3);
      repeat (n) send_word(random_byte(PICK_SEP), 1'b0);
    end else if (pick < 33) begin
      // up to 12 digits, so long runs saturate
      n = $urandom_range(1, 12);
      repeat (n) send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 53) begin
      send_word(CH_DQUOTE, 1'b0);
      n = $urandom_range(0, 20);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          send_word(CH_BSLASH, 1'b0);
          send_word(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_word(random_byte(PICK_STR), 1'b0);
        end
      end
      case ($urandom_range(0, 19))
        0:       send_end();
        1:       ;  // leave the string open
        default: send_word(CH_DQUOTE, 1'b0);
      endcase
    end else if (pick < 68) begin
      send_word(random_byte(PICK_IDENT_START), 1'b0);
      n = $urandom_range(0, 15);
      repeat (n) send_word(random_byte(PICK_IDENT), 1'b0);
    end else if (pick < 76) begin
      send_word(CH_SEMI, 1'b0);
      n = $urandom_range(0, 10);
      repeat (n) send_word(random_byte(PICK_COMMENT), 1'b0);
      if ($urandom_range(0, 9) == 0) send_end();
      else send_word(CH_LF, 1'b0);
    end else if (pick < 82) begin
      send_end();
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- test tasks

  task automatic test_directed();
    send_text("()'.\t");
    // digits then a letter, identifier extended by ; ' . and a digit
    send_text("12a;'.9");
    send_word(CH_CR, 1'b0);
    // escaped quote, then end of input inside an escape
    send_text("\"\\\"\\");
    send_end();
    send_text("\"x\"");
    send_text(";");
    send_end();
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_end();
    send_end();
    send_text("7");
    send_end();
  endtask

  task automatic test_text_overflow();
    // identifier that exactly fills the text buffer
    send_word(random_byte(PICK_IDENT_START), 1'b0);
    repeat (TEXT_CAP - 2) send_word(random_byte(PICK_IDENT), 1'b0);
    send_word(CH_SPACE, 1'b0);
    // string one character short of full, then closed
    send_word(CH_DQUOTE, 1'b0);
    repeat (TEXT_CAP - 2) send_word(random_byte(PICK_STR), 1'b0);
    send_word(CH_DQUOTE, 1'b0);
    // escape pair taking the last two places
    send_word(CH_DQUOTE, 1'b0);
    repeat (TEXT_CAP - 3) send_word(random_byte(PICK_STR), 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_DQUOTE, 1'b0);
    send_end();
  endtask

  task automatic test_random(input int target, input bit vary_gaps);
    int goal;
    goal = live_words + target;
    while (live_words < goal) begin
      if (vary_gaps && $urandom_range(0, 39) == 0) begin
        tx_gaps = $urandom_range(0, 1);
        rx_gaps = $urandom_range(0, 1);
      end
      send_construct();
    end
  endtask

  // Hold the sender until every predicted token has come out
  task automatic test_drain_pause();
    repeat (15) send_construct();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
    repeat (15) send_construct();
  endtask

  task automatic test_full_rate();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random(150, 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_text_overflow();
    test_random(350, 1'b1);
    test_drain_pause();
    test_full_rate();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d source words (%0d lexed, rest skipped), %0d tokens checked",
             words_sent, live_words, tokens_checked);
    $display("Closed %0d integers, %0d strings, %0d identifiers; %0d eof, %0d error tokens",
             kind_hits[sxt_pkg::KIND_INT], kind_hits[sxt_pkg::KIND_STRDONE],
             kind_hits[sxt_pkg::KIND_IDDONE], kind_hits[sxt_pkg::KIND_EOF],
             kind_hits[sxt_pkg::KIND_ERROR]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------------------ checking

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare each accepted output word with the oldest prediction
  always @(posedge clk) begin : rx_check
    token_rec_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      tokens_checked++;
      kind_hits[token_kind]++;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d",
                 $time, token_kind);
        error_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", want.kind, token_kind);
        check_field("text_char", want.ch, text_char);
        check_field("int_value", want.val, int_value);
        check_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  // Stall the output in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16);
      out_stall <= 1'b1;
    end
  end

  // Count cycles with work outstanding but no word moving
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (!in_valid && pending_tokens.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
